// File: src/acpis5_pkg.sv
// ----------------------------------------------------------------------------
// acpis5_pkg
// Shared types, constants and helpers of the S5 sleep type parser.
// ----------------------------------------------------------------------------
package acpis5_pkg;

  // Parser phase
  typedef enum logic [2:0] {
    PH_SEARCH  = 3'd0,
    PH_SEEK    = 3'd1,
    PH_LEN1    = 3'd2,
    PH_LEN2    = 3'd3,
    PH_COUNT   = 3'd4,
    PH_SKIP    = 3'd5,
    PH_ELEM    = 3'd6,
    PH_ELEMVAL = 3'd7
  } phase_t;

  // Byte codes of the table stream
  localparam logic [7:0] OP_PACKAGE  = 8'h12;
  localparam logic [7:0] OP_BYTE     = 8'h0A;
  localparam logic [7:0] OP_WORD     = 8'h0B;
  localparam logic [7:0] OP_ZERO     = 8'h00;
  localparam logic [7:0] OP_ONE      = 8'h01;
  localparam logic [7:0] LEN_EXT_BIT = 8'h80;
  localparam logic [7:0] CH_UNDER    = 8'h5F;  // '_'
  localparam logic [7:0] CH_S        = 8'h53;  // 'S'
  localparam logic [7:0] CH_5        = 8'h35;  // '5'

  // Enable bit of the PM1 control word
  localparam logic [15:0] PM1_SLP_EN = 16'h2000;

  // One result word
  typedef struct packed {
    logic        found;
    logic [7:0]  sleep_type;
    logic [15:0] pm1_control;
  } result_t;

  // Build the PM1 control word: type in bits 15:10 plus the enable bit
  function automatic logic [15:0] pm1_word(input logic [7:0] typ);
    pm1_word = {typ[5:0], 10'b0} | PM1_SLP_EN;
  endfunction

endpackage

// File: src/acpis5_in_if.sv
// ----------------------------------------------------------------------------
// acpis5_in_if
// Byte stream channel: one table byte and its last-byte mark per word.
// ----------------------------------------------------------------------------
interface acpis5_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, data_byte, last_byte, input ready);
  modport sink   (input valid, data_byte, last_byte, output ready);
endinterface

// File: src/acpis5_out_if.sv
// ----------------------------------------------------------------------------
// acpis5_out_if
// Result channel: one decoded sleep type word per table.
// ----------------------------------------------------------------------------
interface acpis5_out_if;
  logic        valid;
  logic        ready;
  logic        found;
  logic [7:0]  sleep_type;
  logic [15:0] pm1_control;

  modport source (output valid, found, sleep_type, pm1_control, input ready);
  modport sink   (input valid, found, sleep_type, pm1_control, output ready);
endinterface

// File: src/acpis5_parse.sv
// ----------------------------------------------------------------------------
// acpis5_parse
// Parser state machine: consumes one byte per step and flags the result.
// ----------------------------------------------------------------------------
module acpis5_parse (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  logic [7:0]          data_byte,
  input  logic                last_byte,
  output logic                emit,
  output acpis5_pkg::result_t result
);

  acpis5_pkg::phase_t phase, phase_next;
  logic [1:0] match_progress, match_progress_next;
  logic [1:0] skip_left, skip_left_next;
  logic       decided, decided_next;

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= acpis5_pkg::PH_SEARCH;
      match_progress <= 2'd0;
      skip_left      <= 2'd0;
      decided        <= 1'b0;
    end else if (step) begin
      phase          <= phase_next;
      match_progress <= match_progress_next;
      skip_left      <= skip_left_next;
      decided        <= decided_next;
    end
  end

  // Next state and result
  always_comb begin
    logic       hit;
    logic       ok;
    logic [7:0] typ;
    hit                 = 1'b0;
    ok                  = 1'b0;
    typ                 = 8'd0;
    phase_next          = phase;
    match_progress_next = match_progress;
    skip_left_next      = skip_left;
    decided_next        = decided;

    if (!decided) begin
      case (phase)
        acpis5_pkg::PH_SEEK: begin
          if (data_byte == acpis5_pkg::OP_PACKAGE) phase_next = acpis5_pkg::PH_LEN1;
        end
        acpis5_pkg::PH_LEN1: begin
          phase_next = ((data_byte & acpis5_pkg::LEN_EXT_BIT) != 8'd0) ?
                       acpis5_pkg::PH_LEN2 : acpis5_pkg::PH_COUNT;
        end
        acpis5_pkg::PH_LEN2: begin
          phase_next = acpis5_pkg::PH_COUNT;
        end
        acpis5_pkg::PH_COUNT: begin
          if (data_byte == acpis5_pkg::OP_BYTE) begin
            skip_left_next = 2'd1;
            phase_next     = acpis5_pkg::PH_SKIP;
          end else if (data_byte == acpis5_pkg::OP_WORD) begin
            skip_left_next = 2'd2;
            phase_next     = acpis5_pkg::PH_SKIP;
          end else begin
            phase_next = acpis5_pkg::PH_ELEM;
          end
        end
        acpis5_pkg::PH_SKIP: begin
          skip_left_next = skip_left - 2'd1;
          if (skip_left_next == 2'd0) phase_next = acpis5_pkg::PH_ELEM;
        end
        acpis5_pkg::PH_ELEM: begin
          if (data_byte inside {acpis5_pkg::OP_BYTE, acpis5_pkg::OP_WORD}) begin
            phase_next = acpis5_pkg::PH_ELEMVAL;
          end else if (data_byte inside {acpis5_pkg::OP_ZERO, acpis5_pkg::OP_ONE}) begin
            hit = 1'b1;
            ok  = 1'b1;
            typ = data_byte;
          end else begin
            hit = 1'b1;
          end
        end
        acpis5_pkg::PH_ELEMVAL: begin
          hit = 1'b1;
          ok  = 1'b1;
          typ = data_byte;
        end
        default: begin
          // Name search; a '_' that breaks a partial match restarts it
          phase_next = acpis5_pkg::PH_SEARCH;
          if (match_progress == 2'd2 && data_byte == acpis5_pkg::CH_5) begin
            match_progress_next = 2'd0;
            phase_next          = acpis5_pkg::PH_SEEK;
          end else if (match_progress == 2'd1 && data_byte == acpis5_pkg::CH_S) begin
            match_progress_next = 2'd2;
          end else begin
            match_progress_next = (data_byte == acpis5_pkg::CH_UNDER) ? 2'd1 : 2'd0;
          end
        end
      endcase
    end

    // Close the table on the last byte, or latch the decision
    if (last_byte) begin
      if (!decided && !hit) begin
        hit = 1'b1;
        ok  = 1'b0;
        typ = 8'd0;
      end
      phase_next          = acpis5_pkg::PH_SEARCH;
      match_progress_next = 2'd0;
      skip_left_next      = 2'd0;
      decided_next        = 1'b0;
    end else if (hit) begin
      decided_next = 1'b1;
    end

    // Flag that the presented byte gives a result if it is stepped
    emit               = hit;
    result.found       = ok;
    result.sleep_type  = typ;
    result.pm1_control = acpis5_pkg::pm1_word(typ);
  end

  // A pending skip count only lives in the skip phase
  a_skip_phase: assert property (@(posedge clk) disable iff (rst)
    (skip_left != 2'd0) |-> (phase == acpis5_pkg::PH_SKIP))
    else $error("skip count set outside skip phase");

  // The last byte returns the parser to its idle search
  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    (step && last_byte) |=> (phase == acpis5_pkg::PH_SEARCH && !decided &&
                             match_progress == 2'd0))
    else $error("state not cleared after last byte");

  // No second result for a table once decided
  a_no_repeat: assert property (@(posedge clk) disable iff (rst)
    (decided && step && !last_byte) |-> !emit)
    else $error("result given twice for one table");

endmodule

// File: src/acpi_s5_sleep_type_parser_top.sv
// ----------------------------------------------------------------------------
// acpi_s5_sleep_type_parser_top
// Extracts the S5 sleep type and PM1 control word from a streamed table.
// ----------------------------------------------------------------------------
// Usage:
//   item   : one table byte per word (data_byte, last_byte marks the end).
//   result : one word per table (found, sleep_type, pm1_control), given as
//            soon as the outcome is decided, or at the last byte otherwise.
//   Throughput is one byte per cycle while the input does not stall. A byte
//   goes into an input register, the parser steps on it from there and any
//   result lands in the output register, or in the skid word if that is full.
//   The output side is a two-word buffer (output register plus skid word):
//   bytes keep flowing while a result waits. Only when both words are full
//   and the staged byte would produce a result does the input stall; bytes
//   that produce nothing still pass.
//   Reset clears the parser to the name search and empties all buffers.
// ----------------------------------------------------------------------------
module acpi_s5_sleep_type_parser_top (
  input  logic         clk,
  input  logic         rst,
  acpis5_in_if.sink    item,
  acpis5_out_if.source result
);

  logic                s_valid;
  logic [7:0]          s_byte;
  logic                s_last;
  logic                fire;
  logic                emit;
  acpis5_pkg::result_t res;
  logic                out_valid;
  acpis5_pkg::result_t out_word;
  logic                skid_valid;
  acpis5_pkg::result_t skid_word;
  logic                pop;
  logic                push;

  acpis5_parse u_parse (
    .clk       (clk),
    .rst       (rst),
    .step      (fire),
    .data_byte (s_byte),
    .last_byte (s_last),
    .emit      (emit),
    .result    (res)
  );

  // Step the staged byte unless its result has nowhere to go
  assign pop        = out_valid && result.ready;
  assign fire       = s_valid && (!skid_valid || !emit);
  assign push       = fire && emit;
  assign item.ready = !s_valid || fire;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (item.ready) begin
      s_valid <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item.ready && item.valid) begin
      s_byte <= item.data_byte;
      s_last <= item.last_byte;
    end
  end

  // Output register and skid word
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (push) begin
        if (out_valid && !pop) begin
          skid_valid <= 1'b1;
        end else begin
          out_valid <= 1'b1;
        end
      end else if (pop) begin
        if (skid_valid) begin
          skid_valid <= 1'b0;
        end else begin
          out_valid <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      if (out_valid && !pop) begin
        skid_word <= res;
      end else begin
        out_word <= res;
      end
    end else if (pop && skid_valid) begin
      out_word <= skid_word;
    end
  end

  assign result.valid       = out_valid;
  assign result.found       = out_word.found;
  assign result.sleep_type  = out_word.sleep_type;
  assign result.pm1_control = out_word.pm1_control;

  // Skid word is only filled behind a full output register
  a_skid_order: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid word valid with empty output register");

  // A waiting skid word is not dropped
  a_skid_hold: assert property (@(posedge clk) disable iff (rst)
    (skid_valid && !pop) |=> skid_valid)
    else $error("skid word lost while output stalled");

  // Input stalls only behind a staged byte that cannot step
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !item.ready |-> (s_valid && skid_valid && emit))
    else $error("input stalled without cause");

endmodule
